/* hdl/jump_table_parameter_sequencer_core_assert.svh */
// Assertion macros used by the checker of the jump table sequencer.
`ifndef JUMP_TABLE_PARAMETER_SEQUENCER_CORE_ASSERT_SVH
`define JUMP_TABLE_PARAMETER_SEQUENCER_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define JTPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Assertion whose consequent is checked in the cycle after its antecedent.
`define JTPS_ASSERT_NEXT(label, ante, cons, msg) \
    `JTPS_ASSERT(label, ante |=> cons, msg)

`endif

/* hdl/jtps_pkg.sv */
// Shared types and constants of the jump table parameter sequencer.
package jtps_pkg;

    localparam int DEPTH      = 64;
    localparam int ROW_W      = 6;
    localparam int VAL_W      = 16;
    localparam int JMP_W      = 7;
    localparam int NJMP_W     = 8;
    localparam int LEN_W      = 7;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 48;

    localparam logic signed [JMP_W-1:0]  JUMP_ADVANCE = -7'sd1;
    localparam logic signed [NJMP_W-1:0] JUMP_HOLD    = -8'sd2;

    localparam logic signed [VAL_W-1:0] VALUE_MIN_RESET    = -16'sd32768;
    localparam logic signed [VAL_W-1:0] VALUE_MAX_RESET    = 16'sd32767;
    localparam logic [LEN_W-1:0]        TABLE_LENGTH_RESET = 7'd64;
    localparam logic [ROW_W-1:0]        RESTART_RESET      = 6'd0;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_RESTART = 2'd1,
        MODE_WRITE   = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_min;
        logic signed [VAL_W-1:0] value_max;
        logic [LEN_W-1:0]        table_length;
        logic [ROW_W-1:0]        restart_position;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic step;
        logic lookup;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_status_t;

endpackage

/* hdl/jtps_cfg.sv */
// Configuration register file with its APB-style access port.
module jtps_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jtps_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [jtps_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [jtps_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output jtps_pkg::cfg_t                    cfg
);

    typedef enum logic [1:0] {
        REG_VALUE_MIN    = 2'd0,
        REG_VALUE_MAX    = 2'd1,
        REG_TABLE_LENGTH = 2'd2,
        REG_RESTART      = 2'd3
    } reg_index_t;

    jtps_pkg::cfg_t cfg_reg;
    reg_index_t     reg_index;
    logic           wr_en;

    function automatic logic [jtps_pkg::CFG_DATA_W-1:0] CFG_DATA_W_SEXT(
        input logic signed [jtps_pkg::VAL_W-1:0] v
    );
        return {{(jtps_pkg::CFG_DATA_W-jtps_pkg::VAL_W){v[jtps_pkg::VAL_W-1]}}, v};
    endfunction

    assign reg_index = reg_index_t'(paddr[3:2]);
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.value_min        <= jtps_pkg::VALUE_MIN_RESET;
            cfg_reg.value_max        <= jtps_pkg::VALUE_MAX_RESET;
            cfg_reg.table_length     <= jtps_pkg::TABLE_LENGTH_RESET;
            cfg_reg.restart_position <= jtps_pkg::RESTART_RESET;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_VALUE_MIN:    cfg_reg.value_min <= pwdata[jtps_pkg::VAL_W-1:0];
                REG_VALUE_MAX:    cfg_reg.value_max <= pwdata[jtps_pkg::VAL_W-1:0];
                REG_TABLE_LENGTH: cfg_reg.table_length <= pwdata[jtps_pkg::LEN_W-1:0];
                REG_RESTART:      cfg_reg.restart_position <= pwdata[jtps_pkg::ROW_W-1:0];
                default:          cfg_reg.value_min <= cfg_reg.value_min;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_VALUE_MIN:    prdata = CFG_DATA_W_SEXT(cfg_reg.value_min);
            REG_VALUE_MAX:    prdata = CFG_DATA_W_SEXT(cfg_reg.value_max);
            REG_TABLE_LENGTH: prdata = {{(jtps_pkg::CFG_DATA_W-jtps_pkg::LEN_W){1'b0}},
                                        cfg_reg.table_length};
            REG_RESTART:      prdata = {{(jtps_pkg::CFG_DATA_W-jtps_pkg::ROW_W){1'b0}},
                                        cfg_reg.restart_position};
            default:          prdata = '0;
        endcase
    end

endmodule

/* hdl/jtps_ctrl.sv */
// Controller state machine that sequences one item through the datapath.
module jtps_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  jtps_pkg::dp_status_t    status,
    output jtps_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_STEP,
        S_LOOK,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    assign s_tready = ready_reg;

    always_comb begin
        cmd.capture = ready_reg & s_tvalid;
        cmd.fetch   = (state_reg == S_FETCH);
        cmd.step    = (state_reg == S_STEP);
        cmd.lookup  = (state_reg == S_LOOK);
        cmd.finish  = (state_reg == S_DONE) & ~status.out_stall;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_FETCH;
                        ready_reg <= 1'b0;
                    end
                end
                S_FETCH: state_reg <= S_STEP;
                S_STEP:  state_reg <= S_LOOK;
                S_LOOK:  state_reg <= S_DONE;
                S_DONE: begin
                    if (!status.out_stall) begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

/* hdl/jtps_dp.sv */
// Datapath with the row tables, position register and result register.
module jtps_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  jtps_pkg::cfg_t                  cfg,
    input  jtps_pkg::ctrl_cmd_t             cmd,
    output jtps_pkg::dp_status_t            status,
    input  logic [1:0]                      s_tuser,
    input  logic [jtps_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [jtps_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int ROW_W  = jtps_pkg::ROW_W;
    localparam int VAL_W  = jtps_pkg::VAL_W;
    localparam int JMP_W  = jtps_pkg::JMP_W;
    localparam int NJMP_W = jtps_pkg::NJMP_W;
    localparam int LEN_W  = jtps_pkg::LEN_W;
    localparam int DEPTH  = jtps_pkg::DEPTH;
    localparam int PAD_W  = jtps_pkg::M_DATA_W - (2 * VAL_W + ROW_W + 1 + JMP_W);

    logic signed [VAL_W-1:0] val_mem [DEPTH];
    logic signed [JMP_W-1:0] jmp_mem [DEPTH];
    logic [DEPTH-1:0]        valid_reg;

    jtps_pkg::mode_t          mode_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [ROW_W-1:0]         cur_reg;
    logic signed [VAL_W-1:0]  nval_reg;
    logic signed [NJMP_W-1:0] njmp_reg;
    logic [ROW_W-1:0]         position_reg;
    logic [ROW_W-1:0]         position_next;
    logic signed [VAL_W-1:0]  vcur_reg;
    logic signed [VAL_W-1:0]  rd_val_reg;
    logic signed [JMP_W-1:0]  rd_jmp_reg;
    logic signed [VAL_W-1:0]  a_val_reg;
    logic signed [JMP_W-1:0]  a_jmp_reg;
    logic signed [VAL_W-1:0]  b_val_reg;
    logic signed [JMP_W-1:0]  b_jmp_reg;
    logic                     m_tvalid_reg;
    logic [jtps_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic [ROW_W-1:0]         last_row;
    logic [ROW_W-1:0]         addr_a;
    logic [ROW_W-1:0]         tick_next;
    logic signed [VAL_W-1:0]  val_hi;
    logic signed [VAL_W-1:0]  wr_val;
    logic signed [NJMP_W-1:0] last_signed;
    logic signed [NJMP_W-1:0] jmp_hi;
    logic signed [NJMP_W-1:0] wr_jmp;
    logic                     wr_en;
    logic                     changed;

    function automatic logic [ROW_W-1:0] clip_row(
        input logic [ROW_W-1:0] r,
        input logic [ROW_W-1:0] last
    );
        return (r > last) ? last : r;
    endfunction

    always_comb begin
        if (cfg.table_length == '0) begin
            last_row = '0;
        end else if (cfg.table_length > LEN_W'(DEPTH)) begin
            last_row = ROW_W'(DEPTH - 1);
        end else begin
            last_row = ROW_W'(cfg.table_length - 1'b1);
        end
    end

    always_comb begin
        val_hi      = (nval_reg < cfg.value_max) ? nval_reg : cfg.value_max;
        wr_val      = (val_hi < cfg.value_min) ? cfg.value_min : val_hi;
        last_signed = $signed({{(NJMP_W-ROW_W){1'b0}}, last_row});
        jmp_hi      = (njmp_reg < last_signed) ? njmp_reg : last_signed;
        wr_jmp      = (jmp_hi < jtps_pkg::JUMP_HOLD) ? jtps_pkg::JUMP_HOLD : jmp_hi;
        wr_en       = cmd.fetch & (mode_reg == jtps_pkg::MODE_WRITE);
        addr_a      = cmd.lookup ? position_reg : cur_reg;
    end

    always_comb begin
        if (!a_jmp_reg[JMP_W-1]) begin
            tick_next = clip_row(a_jmp_reg[ROW_W-1:0], last_row);
        end else if (a_jmp_reg == jtps_pkg::JUMP_ADVANCE) begin
            tick_next = (cur_reg == last_row) ? last_row : cur_reg + 1'b1;
        end else begin
            tick_next = cur_reg;
        end
    end

    always_comb begin
        position_next = position_reg;
        if (cmd.step) begin
            case (mode_reg)
                jtps_pkg::MODE_TICK:    position_next = tick_next;
                jtps_pkg::MODE_RESTART: position_next = clip_row(cfg.restart_position,
                                                                 last_row);
                default:                position_next = position_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            val_mem[row_reg] <= wr_val;
            jmp_mem[row_reg] <= wr_jmp[JMP_W-1:0];
        end
        if (cmd.fetch || cmd.lookup) begin
            a_val_reg <= valid_reg[addr_a] ? val_mem[addr_a] : '0;
            a_jmp_reg <= valid_reg[addr_a] ? jmp_mem[addr_a] : '0;
        end
        b_val_reg <= valid_reg[row_reg] ? val_mem[row_reg] : '0;
        b_jmp_reg <= valid_reg[row_reg] ? jmp_mem[row_reg] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            position_reg <= '0;
        end else begin
            if (wr_en) begin
                valid_reg[row_reg] <= 1'b1;
            end
            position_reg <= position_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= jtps_pkg::mode_t'(s_tuser);
            row_reg  <= clip_row(s_tdata[ROW_W-1:0], last_row);
            nval_reg <= s_tdata[ROW_W +: VAL_W];
            njmp_reg <= s_tdata[ROW_W+VAL_W +: NJMP_W];
            cur_reg  <= clip_row(position_reg, last_row);
        end
        if (cmd.step) begin
            vcur_reg <= a_val_reg;
            if (mode_reg == jtps_pkg::MODE_READ) begin
                rd_val_reg <= b_val_reg;
                rd_jmp_reg <= b_jmp_reg;
            end else begin
                rd_val_reg <= '0;
                rd_jmp_reg <= '0;
            end
        end
    end

    assign changed = (mode_reg == jtps_pkg::MODE_TICK) && (a_val_reg != vcur_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, rd_jmp_reg, rd_val_reg, changed,
                            position_reg, a_val_reg};
        end
    end

    assign status.out_stall = m_tvalid_reg & ~m_tready;
    assign m_tvalid         = m_tvalid_reg;
    assign m_tdata          = m_tdata_reg;

endmodule

/* hdl/jump_table_parameter_sequencer_core.sv */
// Jump table parameter sequencer: a table of value and jump rows stepped by items.
//
// The input channel (s_) carries one item: s_tuser holds the mode (tick,
// restart, write row, read row), s_tdata holds the row, value and jump code.
// The result channel (m_) returns exactly one result for every item, in order.
// The APB-style port sets the value limits, the table length in use and the
// restart row; write it only while no item is in flight.
// Each item is accepted, then the jump and value tables are read at the
// current row, the new position is formed, the value at the new position
// is read, and the result is loaded into the output register.
// The result shows on m_tvalid when it is loaded there, and s_tready rises
// again in the same cycle, so a new item is taken only after the last one's result is loaded.
// The two table reads are registered and run one after the other.
// When the receiver stalls, the result waits in the output register and the
// next item is taken and worked on; its result is held back until the
// output register is free. Reset clears the position, marks every table row
// as reading zero and loads the register defaults; no clearing pass is run.
module jump_table_parameter_sequencer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: row_index[5:0], new_value[21:6], new_jump[29:22], zero pad.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [jtps_pkg::S_DATA_W-1:0]     s_tdata,
    // s_tuser: mode[1:0].
    input  logic [1:0]                        s_tuser,
    // m_tdata: current_value[15:0], current_position[21:16],
    // value_changed[22], read_value[38:23], read_jump[45:39], zero pad.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [jtps_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jtps_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [jtps_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [jtps_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    jtps_pkg::cfg_t       cfg;
    jtps_pkg::ctrl_cmd_t  cmd;
    jtps_pkg::dp_status_t status;

    jtps_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jtps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    jtps_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* hdl/jtps_checker.sv */
// Port-level checker of the jump table sequencer and its bind to the top level.
`include "jump_table_parameter_sequencer_core_assert.svh"

module jtps_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [jtps_pkg::M_DATA_W-1:0]   m_tdata
);

    `JTPS_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid, "Result dropped.")
    `JTPS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "Item taken while busy.")
    `JTPS_ASSERT_NEXT(a_data_held, m_tvalid && !m_tready, $stable(m_tdata), "Result changed.")
    `JTPS_ASSERT(a_tick_only, m_tvalid && m_tdata[22] |-> m_tdata[45:23] == '0, "Bad tick.")

endmodule

bind jump_table_parameter_sequencer_core jtps_checker u_jtps_checker (.*);
